// File: rtl/ghal_pkg.sv
// ghal_pkg: shared types and codes for the generational handle allocator
// no dependencies; imported by the allocator top level and its checker

package ghal_pkg;

  // fixed field widths of the request and response transfers
  localparam int CMD_W     = 3;
  localparam int IDX_IN_W  = 8;
  localparam int VER_IN_W  = 16;
  localparam int STATUS_W  = 2;
  localparam int IDX_OUT_W = 8;
  localparam int VER_OUT_W = 16;
  localparam int LIVE_W    = 9;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [IDX_IN_W-1:0] slot_index;
    logic [VER_IN_W-1:0] handle_version;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 handle_ok;
    logic [IDX_OUT_W-1:0] out_index;
    logic [VER_OUT_W-1:0] out_version;
    logic [LIVE_W-1:0]    live_count;
  } rsp_t;

endpackage

// File: rtl/ghal_ram.sv
// ghal_ram: simple dual-port synchronous ram, one write and one read port
// read data registered; no dependencies

module ghal_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/generational_handle_allocator.sv
// generational_handle_allocator: slot handle allocator with version table and free stack
// depends on ghal_pkg and ghal_ram (version table and free stack memories)
//
//   channel   signals               transfer when
//   request   start, busy, req      start high and busy low at a rising edge
//   response  done, rsp             done high for one cycle, always taken
//
// a request is taken while idle and the memories are read at that edge; the look state
// decides and writes back, and the response is registered out of it.
// create that pops the free stack needs a second version table read, so it
// holds busy through the look and pop states; every other command only through look.
// one request is in flight at a time.
// rst is synchronous and empties the allocator; memory contents are not cleared.
// the receiver cannot stall: done is a single-cycle strobe.

module generational_handle_allocator
  import ghal_pkg::*;
#(
  parameter int SLOTS        = 256,
  parameter int VERSION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0] next_fresh, next_fresh_next;
  logic [CNT_W-1:0] free_depth, free_depth_next;
  logic [CNT_W-1:0] free_dec;

  // latched request
  logic [CMD_W-1:0]        cmd_q;
  logic [CMP_W-1:0]        idx_q;
  logic [VERSION_BITS-1:0] ver_q;
  logic [IDX_W-1:0]        slot_q, slot_next;
  logic [CMP_W-1:0]        req_idx_ext;

  // memory ports
  logic                    ver_we;
  logic [IDX_W-1:0]        ver_waddr, ver_raddr;
  logic [VERSION_BITS-1:0] ver_wdata, ver_rd;
  logic                    stk_we;
  logic [IDX_W-1:0]        stk_waddr, stk_raddr, stk_wdata, stk_rd;

  logic accept;
  logic emit;
  logic in_range;
  logic ver_valid;
  rsp_t rsp_next;

  assign busy        = (state != S_IDLE);
  assign accept      = start && (state == S_IDLE);
  assign req_idx_ext = CMP_W'(req.slot_index);
  assign free_dec    = free_depth - CNT_W'(1);
  assign in_range    = idx_q < CMP_W'(next_fresh);
  assign ver_valid   = in_range && (ver_q >= ver_rd);

  // version per slot
  ghal_ram #(
    .WIDTH (VERSION_BITS),
    .DEPTH (SLOTS)
  ) u_ver_ram (
    .clk   (clk),
    .we    (ver_we),
    .waddr (ver_waddr),
    .wdata (ver_wdata),
    .raddr (ver_raddr),
    .rdata (ver_rd)
  );

  // stack of freed slot indexes
  ghal_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rd)
  );

  // decide, update counters and write back
  always_comb begin
    state_next      = state;
    next_fresh_next = next_fresh;
    free_depth_next = free_depth;
    slot_next       = slot_q;
    ver_we          = 1'b0;
    ver_waddr       = idx_q[IDX_W-1:0];
    ver_wdata       = ver_rd + VERSION_BITS'(1);
    ver_raddr       = req_idx_ext[IDX_W-1:0];
    stk_we          = 1'b0;
    stk_waddr       = free_depth[IDX_W-1:0];
    stk_wdata       = idx_q[IDX_W-1:0];
    stk_raddr       = free_dec[IDX_W-1:0];
    emit            = 1'b0;
    rsp_next        = '0;
    rsp_next.status = ST_INVALID;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_LOOK;
        end
      end

      S_LOOK: begin
        emit       = 1'b1;
        state_next = S_IDLE;
        unique case (cmd_q)
          CMD_CREATE: begin
            if (free_depth != '0) begin
              // reuse the most recently freed slot, fetch its version next
              emit            = 1'b0;
              free_depth_next = free_dec;
              slot_next       = stk_rd;
              ver_raddr       = stk_rd;
              state_next      = S_POP;
            end else if (next_fresh < CNT_W'(SLOTS)) begin
              ver_we              = 1'b1;
              ver_waddr           = next_fresh[IDX_W-1:0];
              ver_wdata           = '0;
              next_fresh_next     = next_fresh + CNT_W'(1);
              rsp_next.status     = ST_OK;
              rsp_next.handle_ok  = 1'b1;
              rsp_next.out_index  = IDX_OUT_W'(next_fresh);
            end else begin
              rsp_next.status = ST_FULL;
            end
          end
          CMD_DESTROY: begin
            if (ver_valid && (free_depth < next_fresh)) begin
              ver_we             = 1'b1;
              stk_we             = 1'b1;
              free_depth_next    = free_depth + CNT_W'(1);
              rsp_next.status    = ST_OK;
              rsp_next.handle_ok = 1'b1;
            end
          end
          CMD_CHECK: begin
            if (ver_valid) begin
              rsp_next.status    = ST_OK;
              rsp_next.handle_ok = 1'b1;
            end
          end
          CMD_GET: begin
            if (in_range) begin
              rsp_next.status      = ST_OK;
              rsp_next.handle_ok   = 1'b1;
              rsp_next.out_index   = IDX_OUT_W'(idx_q);
              rsp_next.out_version = VER_OUT_W'(ver_rd);
            end
          end
          CMD_CLEAR: begin
            next_fresh_next    = '0;
            free_depth_next    = '0;
            rsp_next.status    = ST_OK;
            rsp_next.handle_ok = 1'b1;
          end
          default: begin
            rsp_next.status = ST_INVALID;
          end
        endcase
      end

      S_POP: begin
        emit                 = 1'b1;
        state_next           = S_IDLE;
        rsp_next.status      = ST_OK;
        rsp_next.handle_ok   = 1'b1;
        rsp_next.out_index   = IDX_OUT_W'(slot_q);
        rsp_next.out_version = VER_OUT_W'(ver_rd);
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // live count after this step
    rsp_next.live_count = LIVE_W'(next_fresh_next - free_depth_next);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_fresh <= '0;
      free_depth <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      next_fresh <= next_fresh_next;
      free_depth <= free_depth_next;
      done       <= emit;
    end
  end

  // request latch and response register
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= req.command;
      idx_q <= req_idx_ext;
      ver_q <= VERSION_BITS'(req.handle_version);
    end
    slot_q <= slot_next;
    if (emit) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: rtl/ghal_checker.sv
// ghal_checker: port-level assertions for the generational handle allocator
// depends on ghal_pkg; bound to generational_handle_allocator below

module ghal_checker
  import ghal_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  logic [LIVE_W-1:0] last_live;

  // live count of the previous response
  always_ff @(posedge clk) begin
    if (rst) begin
      last_live <= '0;
    end else if (done) begin
      last_live <= rsp.live_count;
    end
  end

  // a taken request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request transfer not followed by busy");

  // a response only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("response without work in progress");

  // responses never come in adjacent cycles
  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back response strobes");

  // a refused command leaves the live count unchanged
  a_refused_keeps_live: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> (rsp.live_count == last_live))
    else $error("live count moved on a refused command");

endmodule

bind generational_handle_allocator ghal_checker u_ghal_checker (.*);
